[rtl/mpt_pkg.sv]
// Package with shared types and constants for the mount prefix table.
`timescale 1ns / 1ps
package mpt_pkg;

  // Operation codes taken from func_i with the first byte of a string.
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_NO_MATCH  = 3'd5;

  localparam logic [7:0] SLASH_BYTE = 8'h2F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cmp;
    logic scan;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_end;
    logic scan_last;
  } stat_t;

endpackage

[rtl/mount_prefix_table.sv]
// Top level of the mount prefix table.
`timescale 1ns / 1ps
// A string is sent one byte per transfer (start_i while busy_o is low) and ends
// with a zero byte; the operation comes from func_i with the first byte. For
// each ordinary byte the per-slot name memories are read at the current
// position and the byte is then compared. After the terminating byte, the
// slot walk that finds the exact and the longest covering match visits one
// slot per cycle. The result appears on done_o for one cycle and cannot be
// stalled; the receiver must take it then.
module mount_prefix_table
  import mpt_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       func_i,
  input  logic [7:0]                       ch_i,
  input  logic [7:0]                       fs_type_i,
  input  logic [31:0]                      mount_handle_i,
  output logic                             done_o,
  output logic [2:0]                       status_o,
  output logic [7:0]                       type_out_o,
  output logic [31:0]                      handle_out_o,
  output logic [$clog2(NAME_BYTES+1)-1:0]  rel_offset_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  mpt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // Datapath.
  mpt_dp #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (func_i),
    .ch_i          (ch_i),
    .fs_type_i     (fs_type_i),
    .mount_handle_i(mount_handle_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .type_out_o    (type_out_o),
    .handle_out_o  (handle_out_o),
    .rel_offset_o  (rel_offset_o)
  );

endmodule

[rtl/mpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mpt_ctrl.sv]
// Controller state machine for the mount prefix table.
`timescale 1ns / 1ps
module mpt_ctrl
  import mpt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_CMP;
      S_CMP:  state_d = stat_i.is_end ? S_SCAN : S_IDLE;
      S_SCAN: if (stat_i.scan_last) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_CMP:  cmd_o.cmp = 1'b1;
      S_SCAN: cmd_o.scan = 1'b1;
      S_DONE: cmd_o.finish = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

[rtl/mpt_dp.sv]
// Datapath: name memories, entry table, match flags and result registers.
`timescale 1ns / 1ps
module mpt_dp
  import mpt_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 64,
  localparam int IW = $clog2(ENTRIES),
  localparam int LW = $clog2(NAME_BYTES),
  localparam int PW = $clog2(NAME_BYTES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output stat_t         stat_o,
  input  logic [1:0]    func_i,
  input  logic [7:0]    ch_i,
  input  logic [7:0]    fs_type_i,
  input  logic [31:0]   mount_handle_i,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic [7:0]    type_out_o,
  output logic [31:0]   handle_out_o,
  output logic [PW-1:0] rel_offset_o
);

  localparam logic [PW-1:0] POS_MAX = PW'(NAME_BYTES);

  // Per-string registers.
  op_e               op_q;
  logic              slash_q;
  logic [7:0]        ch_q;
  logic [7:0]        type_q;
  logic [31:0]       handle_q;
  logic [PW-1:0]     pos_q;
  logic [ENTRIES-1:0] eq_q;
  logic [ENTRIES-1:0] cov_q;

  // Entry table.
  logic [ENTRIES-1:0] used_q;
  logic [LW-1:0]      len_q    [ENTRIES];
  logic [7:0]         etype_q  [ENTRIES];
  logic [31:0]        ehandle_q[ENTRIES];

  // Scan state.
  logic [IW-1:0] scan_q;
  logic          hit_vld_q, best_vld_q;
  logic [IW-1:0] hit_q, best_q;
  logic [LW-1:0] best_len_q;

  // Result registers.
  logic          done_q;
  logic [2:0]    status_q;
  logic [7:0]    type_out_q;
  logic [31:0]   handle_out_q;
  logic [PW-1:0] rel_q;

  logic [7:0]    rdata [ENTRIES];
  logic          in_range;
  logic          free_vld;
  logic [IW-1:0] free_idx;

  assign in_range = (pos_q < POS_MAX);

  // Lowest free slot.
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_vld = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // One byte-wide name memory per slot, all read at the current position.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_name
    mpt_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_ram (
      .clk_i  (clk_i),
      .we_i   (cmd_i.cmp && ch_q != END_BYTE && op_q == OP_ADD && in_range &&
               free_vld && free_idx == IW'(g)),
      .waddr_i(pos_q[LW-1:0]),
      .wdata_i(ch_q),
      .re_i   (cmd_i.load && in_range),
      .raddr_i(pos_q[LW-1:0]),
      .rdata_o(rdata[g])
    );
  end

  assign stat_o.is_end    = (ch_q == END_BYTE);
  assign stat_o.scan_last = (scan_q == IW'(ENTRIES - 1));

  // Control registers of the string and the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_ADD;
      slash_q    <= 1'b0;
      pos_q      <= '0;
      eq_q       <= '1;
      cov_q      <= '0;
      used_q     <= '0;
      scan_q     <= '0;
      hit_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
      done_q     <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) len_q[i] <= '0;
    end else begin
      done_q <= 1'b0;
      // Accept a byte.
      if (cmd_i.load && pos_q == '0) begin
        op_q    <= op_e'(func_i);
        slash_q <= (ch_i == SLASH_BYTE);
      end
      // Compare the byte against every entry at this position.
      if (cmd_i.cmp) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (used_q[i] && eq_q[i]) begin
            if (PW'(len_q[i]) == pos_q && (ch_q == END_BYTE || ch_q == SLASH_BYTE)) begin
              cov_q[i] <= 1'b1;
            end
            if (pos_q < PW'(len_q[i]) && in_range && rdata[i] != ch_q) begin
              eq_q[i] <= 1'b0;
            end
          end
        end
        if (ch_q != END_BYTE) begin
          if (in_range) pos_q <= pos_q + PW'(1);
        end else begin
          scan_q     <= '0;
          hit_vld_q  <= 1'b0;
          best_vld_q <= 1'b0;
        end
      end
      // Walk the slots: first exact match and longest covering prefix.
      if (cmd_i.scan) begin
        scan_q <= scan_q + IW'(1);
        if (used_q[scan_q] && eq_q[scan_q] && PW'(len_q[scan_q]) == pos_q && !hit_vld_q) begin
          hit_vld_q <= 1'b1;
          hit_q     <= scan_q;
        end
        if (used_q[scan_q] && cov_q[scan_q] &&
            (!best_vld_q || len_q[scan_q] > best_len_q)) begin
          best_vld_q <= 1'b1;
          best_q     <= scan_q;
          best_len_q <= len_q[scan_q];
        end
      end
      // Carry out the operation and start a fresh string.
      if (cmd_i.finish) begin
        done_q <= (op_q != OP_NONE);
        if (op_q == OP_ADD && pos_q != '0 && in_range && !hit_vld_q && free_vld) begin
          used_q[free_idx] <= 1'b1;
          len_q[free_idx]  <= pos_q[LW-1:0];
        end
        if (op_q == OP_REMOVE && hit_vld_q) begin
          used_q[hit_q] <= 1'b0;
          len_q[hit_q]  <= '0;
        end
        pos_q <= '0;
        eq_q  <= '1;
        cov_q <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q     <= ch_i;
      type_q   <= fs_type_i;
      handle_q <= mount_handle_i;
    end
    if (cmd_i.finish) begin
      status_q     <= ST_OK;
      type_out_q   <= '0;
      handle_out_q <= '0;
      rel_q        <= '0;
      unique case (op_q)
        OP_ADD: begin
          if (pos_q == '0 || !in_range) status_q <= ST_BAD_LEN;
          else if (hit_vld_q)           status_q <= ST_EXISTS;
          else if (!free_vld)           status_q <= ST_FULL;
          else begin
            etype_q[free_idx]   <= type_q;
            ehandle_q[free_idx] <= handle_q;
          end
        end
        OP_REMOVE: begin
          if (!hit_vld_q) status_q <= ST_NOT_FOUND;
          else begin
            type_out_q   <= etype_q[hit_q];
            handle_out_q <= ehandle_q[hit_q];
          end
        end
        OP_RESOLVE: begin
          if (!(slash_q && best_vld_q)) status_q <= ST_NO_MATCH;
          else begin
            type_out_q   <= etype_q[best_q];
            handle_out_q <= ehandle_q[best_q];
            rel_q        <= PW'(best_len_q) + ((PW'(best_len_q) < pos_q) ? PW'(1) : PW'(0));
          end
        end
        default: status_q <= ST_OK;
      endcase
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign type_out_o   = type_out_q;
  assign handle_out_o = handle_out_q;
  assign rel_offset_o = rel_q;

endmodule

[rtl/mpt_checker.sv]
// Port-level checks of the mount prefix table, bound to the top level.
`timescale 1ns / 1ps
module mpt_checker
  import mpt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [2:0] status_o
);

  // A result comes only after a busy stretch, and the block is free then.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result shown while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy_o))
    else $error("result without preceding work");
  // A result strobe lasts one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  // Every accepted byte makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start_i && !busy_o) |=> busy_o)
    else $error("accepted transfer did not raise busy");
  // Status codes stay in their range.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> (status_o <= ST_NO_MATCH))
    else $error("status code out of range");

endmodule

bind mount_prefix_table mpt_checker u_mpt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .status_o(status_o)
);

[tb/mount_prefix_table_test.sv]
// Self-checking testbench for the mount prefix table, with a built-in predictor.
`timescale 1ns / 1ps
module mount_prefix_table_test;
  import mpt_pkg::*;

  typedef byte unsigned bytes_t[$];

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  typ;
    logic [31:0] hdl;
    logic [6:0]  rel;
  } lookup_t;

  // One directed string with an optional result typed in by hand.
  typedef struct {
    op_e         op;
    string       txt;
    logic [7:0]  ftype;
    logic [31:0] handle;
    bit          typed;
    lookup_t     want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  func_i = '0;
  logic [7:0]  ch_i = '0;
  logic [7:0]  fs_type_i = '0;
  logic [31:0] mount_handle_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [2:0]  status_o;
  logic [7:0]  type_out_o;
  logic [31:0] handle_out_o;
  logic [6:0]  rel_offset_o;

  mount_prefix_table dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the table.
  logic [7:0]  tbl_name[16][64];
  logic [5:0]  tbl_len[16];
  logic [7:0]  tbl_type[16];
  logic [31:0] tbl_handle[16];
  logic [15:0] tbl_used = '0;
  int          str_pos = 0;
  logic [15:0] still_equal = '1;
  logic [15:0] covering = '0;
  op_e         str_op = OP_ADD;
  logic        str_slash = 1'b0;

  lookup_t     pending_lookups[$];
  int          errors = 0;
  dir_row_t    dir_rows[$];

  // Advance the shadow table by one byte; returns 1 when a result is due.
  function automatic bit table_step(input logic [1:0] fn, input logic [7:0] c,
                                    input logic [7:0] ft, input logic [31:0] mh,
                                    output lookup_t r);
    int p, hit, best, fr;
    logic [15:0] eq0;
    r = '0;
    hit = -1;
    best = -1;
    fr = -1;
    p = str_pos;
    if (p == 0) begin
      str_op = op_e'(fn);
      str_slash = (c == SLASH_BYTE);
    end
    eq0 = still_equal;
    for (int i = 0; i < 16; i++) begin
      if (tbl_used[i] && eq0[i]) begin
        if (tbl_len[i] == p && (c == END_BYTE || c == SLASH_BYTE)) covering[i] = 1'b1;
        if (p < tbl_len[i] && tbl_name[i][p] != c) still_equal[i] = 1'b0;
      end
    end
    for (int i = 15; i >= 0; i--) if (!tbl_used[i]) fr = i;
    if (c != END_BYTE) begin
      if (str_op == OP_ADD && p < 64 && fr >= 0) tbl_name[fr][p] = c;
      if (p < 64) str_pos = p + 1;
      return 1'b0;
    end
    for (int i = 15; i >= 0; i--)
      if (tbl_used[i] && eq0[i] && tbl_len[i] == p) hit = i;
    str_pos = 0;
    still_equal = '1;
    case (str_op)
      OP_ADD: begin
        if (p == 0 || p >= 64) r.status = ST_BAD_LEN;
        else if (hit >= 0) r.status = ST_EXISTS;
        else if (fr < 0) r.status = ST_FULL;
        else begin
          tbl_len[fr] = p[5:0];
          tbl_type[fr] = ft;
          tbl_handle[fr] = mh;
          tbl_used[fr] = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          r.typ = tbl_type[hit];
          r.hdl = tbl_handle[hit];
          tbl_used[hit] = 1'b0;
          tbl_len[hit] = '0;
        end
      end
      OP_RESOLVE: begin
        if (str_slash)
          for (int i = 0; i < 16; i++)
            if (tbl_used[i] && covering[i] && (best < 0 || tbl_len[i] > tbl_len[best]))
              best = i;
        if (best < 0) r.status = ST_NO_MATCH;
        else begin
          r.typ = tbl_type[best];
          r.hdl = tbl_handle[best];
          r.rel = tbl_len[best] + ((tbl_len[best] < p) ? 7'd1 : 7'd0);
        end
      end
      default: begin
        covering = '0;
        return 1'b0;
      end
    endcase
    covering = '0;
    return 1'b1;
  endfunction

  // Send one string plus its terminator; the sender idles at the given rate.
  task automatic send_string(input logic [1:0] fn, input bytes_t s, input logic [7:0] ft,
                             input logic [31:0] mh, input bit typed, input lookup_t want,
                             input int idle_pct);
    lookup_t r;
    logic [7:0] c;
    for (int k = 0; k <= s.size(); k++) begin
      c = (k < s.size()) ? s[k] : END_BYTE;
      while ($urandom_range(99) < idle_pct) begin
        start_i = 1'b0;
        ch_i = 8'($urandom);
        @(negedge clk_i);
      end
      start_i = 1'b1;
      func_i = (k == 0) ? fn : 2'($urandom);
      ch_i = c;
      fs_type_i = (k == s.size()) ? ft : 8'($urandom);
      mount_handle_i = (k == s.size()) ? mh : $urandom;
      do @(posedge clk_i); while (busy_o);
      if (table_step(func_i, ch_i, fs_type_i, mount_handle_i, r))
        pending_lookups.push_back(typed ? want : r);
      @(negedge clk_i);
    end
  endtask

  function automatic logic [7:0] name_char();
    case ($urandom_range(3))
      0: return "a";
      1: return "b";
      2: return "c";
      default: return SLASH_BYTE;
    endcase
  endfunction

  // Short names over a small alphabet, now and then one near the length limit.
  function automatic bytes_t rand_name();
    bytes_t q;
    int n;
    if ($urandom_range(99) < 4) begin
      case ($urandom_range(4))
        0: n = 62;
        1: n = 63;
        2: n = 64;
        3: n = 65;
        default: n = 70;
      endcase
    end else n = $urandom_range(1, 5);
    for (int k = 0; k < n; k++) q.push_back(name_char());
    if ($urandom_range(99) < 80) q[0] = SLASH_BYTE;
    return q;
  endfunction

  // Name of a random occupied slot, if there is one.
  function automatic bit pick_stored(output bytes_t q);
    int idx[$];
    int i;
    q = {};
    for (int j = 0; j < 16; j++) if (tbl_used[j]) idx.push_back(j);
    if (idx.size() == 0) return 1'b0;
    i = idx[$urandom_range(idx.size() - 1)];
    for (int k = 0; k < tbl_len[i]; k++) q.push_back(tbl_name[i][k]);
    return 1'b1;
  endfunction

  function automatic bytes_t to_bytes(input string s);
    bytes_t q;
    for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    return q;
  endfunction

  task automatic add_row(input op_e op, input string txt, input logic [7:0] ft,
                         input logic [31:0] mh, input bit typed, input lookup_t want);
    dir_row_t row;
    row.op = op;
    row.txt = txt;
    row.ftype = ft;
    row.handle = mh;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Check each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result status=%0d type=%h handle=%h rel=%0d",
                 $time, status_o, type_out_o, handle_out_o, rel_offset_o);
        errors++;
      end else begin
        lookup_t e;
        e = pending_lookups.pop_front();
        if (e.status !== status_o || e.typ !== type_out_o || e.hdl !== handle_out_o ||
            e.rel !== rel_offset_o) begin
          $display("%0t: expected status=%0d type=%h handle=%h rel=%0d", $time,
                   e.status, e.typ, e.hdl, e.rel);
          $display("%0t: actual   status=%0d type=%h handle=%h rel=%0d", $time,
                   status_o, type_out_o, handle_out_o, rel_offset_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("mount_prefix_table_test NOT OK");
    $finish;
  end

  initial begin
    string n63, n64;
    bytes_t s, tail;
    lookup_t none;
    int pct, dice;
    logic [1:0] fn;
    none = '0;
    n63 = "/";
    for (int k = 0; k < 62; k++) n63 = {n63, "m"};
    n64 = {n63, "m"};

    // Directed table: edges of length, every operation and every status but ST_FULL.
    add_row(OP_RESOLVE, "/", 8'h00, 32'h0, 1, '{ST_NO_MATCH, 8'h0, 32'h0, 7'd0});
    add_row(OP_ADD, "", 8'h00, 32'h0, 1, '{ST_BAD_LEN, 8'h0, 32'h0, 7'd0});
    add_row(OP_REMOVE, "/x", 8'h00, 32'h0, 1, '{ST_NOT_FOUND, 8'h0, 32'h0, 7'd0});
    add_row(OP_ADD, "/mnt", 8'hFF, 32'hFFFFFFFF, 1, '{ST_OK, 8'h0, 32'h0, 7'd0});
    add_row(OP_ADD, "/mnt", 8'h11, 32'h1, 1, '{ST_EXISTS, 8'h0, 32'h0, 7'd0});
    add_row(OP_ADD, "/mnt/usb", 8'h00, 32'h0, 1, '{ST_OK, 8'h0, 32'h0, 7'd0});
    add_row(OP_RESOLVE, "/mnt/usb/f", 8'h00, 32'h0, 1, '{ST_OK, 8'h0, 32'h0, 7'd9});
    add_row(OP_RESOLVE, "/mnt", 8'h00, 32'h0, 1, '{ST_OK, 8'hFF, 32'hFFFFFFFF, 7'd4});
    add_row(OP_RESOLVE, "/mntx", 8'h00, 32'h0, 1, '{ST_NO_MATCH, 8'h0, 32'h0, 7'd0});
    add_row(OP_RESOLVE, "mnt", 8'h00, 32'h0, 1, '{ST_NO_MATCH, 8'h0, 32'h0, 7'd0});
    add_row(OP_RESOLVE, "", 8'h00, 32'h0, 1, '{ST_NO_MATCH, 8'h0, 32'h0, 7'd0});
    add_row(OP_ADD, n63, 8'h01, 32'h2, 1, '{ST_OK, 8'h0, 32'h0, 7'd0});
    add_row(OP_ADD, n64, 8'h01, 32'h2, 1, '{ST_BAD_LEN, 8'h0, 32'h0, 7'd0});
    add_row(OP_RESOLVE, {n63, "/"}, 8'h00, 32'h0, 1, '{ST_OK, 8'h01, 32'h2, 7'd64});
    add_row(OP_RESOLVE, {n64, "zz/q"}, 8'h00, 32'h0, 0, none);
    add_row(OP_NONE, "/mnt", 8'h00, 32'h0, 0, none);
    add_row(OP_REMOVE, n63, 8'h00, 32'h0, 1, '{ST_OK, 8'h01, 32'h2, 7'd0});
    add_row(OP_REMOVE, "/mnt", 8'h00, 32'h0, 1, '{ST_OK, 8'hFF, 32'hFFFFFFFF, 7'd0});
    add_row(OP_RESOLVE, "/mnt/usb", 8'h00, 32'h0, 0, none);
    add_row(OP_ADD, "/", 8'h05, 32'h5, 0, none);
    add_row(OP_RESOLVE, "/a/b", 8'h00, 32'h0, 0, none);
    add_row(OP_ADD, "\377\200\001", 8'hA5, 32'h5A5A5A5A, 0, none);
    add_row(OP_RESOLVE, "//", 8'h00, 32'h0, 0, none);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_string(dir_rows[i].op, to_bytes(dir_rows[i].txt), dir_rows[i].ftype,
                  dir_rows[i].handle, dir_rows[i].typed, dir_rows[i].want, 0);

    // Random strings in three phases of sender idling.
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 37 : (ph == 1) ? 86 : 0;
      for (int n = 0; n < 50; n++) begin
        dice = $urandom_range(99);
        if (dice < 38) begin
          fn = OP_ADD;
          if ($urandom_range(9) == 0 && pick_stored(s)) ;
          else s = rand_name();
        end else if (dice < 66) begin
          fn = OP_REMOVE;
          if ($urandom_range(9) < 7 && pick_stored(s)) ;
          else s = rand_name();
        end else if (dice < 92) begin
          fn = OP_RESOLVE;
          if ($urandom_range(9) < 7 && pick_stored(s)) begin
            if ($urandom_range(1)) begin
              tail = rand_name();
              s.push_back(SLASH_BYTE);
              s = {s, tail};
            end
          end else s = rand_name();
        end else begin
          // Noise: any operation code and arbitrary nonzero bytes.
          fn = 2'($urandom);
          s = {};
          for (int k = $urandom_range(0, 8); k > 0; k--)
            s.push_back(8'($urandom_range(1, 255)));
        end
        send_string(fn, s, 8'($urandom), $urandom, 0, none, pct);
      end
    end
    start_i = 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("mount_prefix_table_test OK");
    else $display("mount_prefix_table_test NOT OK");
    $finish;
  end

endmodule
